@@ hdl/rlpm_pkg.sv @@
package rlpm_pkg;

  localparam int SlotW  = 5;
  localparam int AddrW  = 32;
  localparam int IfaceW = 4;
  localparam int LenW   = 6;
  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_e;

  // One queued request; dest carries the lookup address for a lookup.
  typedef struct packed {
    req_e              kind;
    logic [SlotW-1:0]  slot;
    logic              valid;
    logic [AddrW-1:0]  dest;
    logic [AddrW-1:0]  mask;
    logic [AddrW-1:0]  gw;
    logic [IfaceW-1:0] iface;
    logic [LenW-1:0]   len;
  } cmd_t;

  // Stored route, prefix length precomputed at write time.
  typedef struct packed {
    logic [AddrW-1:0]  dest;
    logic [AddrW-1:0]  mask;
    logic [AddrW-1:0]  gw;
    logic [IfaceW-1:0] iface;
    logic [LenW-1:0]   len;
  } route_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      n = n + 4'(v[b]);
    end
    return n;
  endfunction

  function automatic logic [LenW-1:0] popcount32(input logic [AddrW-1:0] v);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = 5'(pop8(v[7:0])) + 5'(pop8(v[15:8]));
    hi = 5'(pop8(v[23:16])) + 5'(pop8(v[31:24]));
    return LenW'(lo) + LenW'(hi);
  endfunction

endpackage

@@ hdl/rlpm_front.sv @@
module rlpm_front #(
  parameter int TABLE_DEPTH = 32,
  parameter int IFACE_COUNT = 16
) (
  input  logic                        start,
  input  logic                        full_i,
  input  logic                        req_type_i,
  input  logic [rlpm_pkg::SlotW-1:0]  slot_i,
  input  logic                        entry_valid_i,
  input  logic [rlpm_pkg::AddrW-1:0]  entry_dest_i,
  input  logic [rlpm_pkg::AddrW-1:0]  entry_mask_i,
  input  logic [rlpm_pkg::AddrW-1:0]  entry_gateway_i,
  input  logic [rlpm_pkg::IfaceW-1:0] entry_iface_i,
  input  logic [rlpm_pkg::AddrW-1:0]  lookup_addr_i,
  output logic                        push_o,
  output rlpm_pkg::cmd_t              cmd_o
);
  import rlpm_pkg::*;

  logic is_lookup;
  logic keep;

  assign is_lookup = (req_e'(req_type_i) == REQ_LOOKUP);

  // Drop writes aimed past the table or at an interface that does not exist.
  assign keep = is_lookup ||
                ((32'(slot_i) < 32'(TABLE_DEPTH)) && (32'(entry_iface_i) < 32'(IFACE_COUNT)));

  assign push_o = start && !full_i && keep;

  always_comb begin
    cmd_o.kind  = req_e'(req_type_i);
    cmd_o.slot  = slot_i;
    cmd_o.valid = entry_valid_i;
    cmd_o.dest  = is_lookup ? lookup_addr_i : entry_dest_i;
    cmd_o.mask  = entry_mask_i;
    cmd_o.gw    = entry_gateway_i;
    cmd_o.iface = entry_iface_i;
    cmd_o.len   = popcount32(entry_mask_i);
  end

endmodule

@@ hdl/rlpm_queue.sv @@
module rlpm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rlpm_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output rlpm_pkg::cmd_t cmd_o,
  output logic           empty_o,
  output logic           full_o
);
  import rlpm_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hdl/rlpm_back.sv @@
module rlpm_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  rlpm_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        done_o,
  output logic                        found_o,
  output logic [rlpm_pkg::AddrW-1:0]  next_hop_o,
  output logic [rlpm_pkg::IfaceW-1:0] out_iface_o,
  output logic [rlpm_pkg::LenW-1:0]   match_len_o
);
  import rlpm_pkg::*;

  // Only slots reachable by the slot field are ever written.
  localparam int EffDepth = (TABLE_DEPTH < (1 << SlotW)) ? TABLE_DEPTH : (1 << SlotW);
  localparam int IdxW     = (EffDepth > 1) ? $clog2(EffDepth) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(EffDepth - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  route_t            mem [EffDepth];
  logic              valid_q [EffDepth];
  route_t            rd_q;
  logic              rd_valid_q;
  logic              chk_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [AddrW-1:0]  addr_q;
  logic              found_q;
  logic [LenW-1:0]   len_q;
  logic [AddrW-1:0]  gw_q;
  logic [IfaceW-1:0] iface_q;
  logic              wr_en;
  logic              start_scan;
  logic              hit;
  logic              better;
  logic [IdxW-1:0]   wr_idx;
  route_t            wr_entry;

  assign pop_o      = (state_q == S_IDLE) && !empty_i;
  assign wr_en      = pop_o && (cmd_i.kind == REQ_WRITE);
  assign start_scan = pop_o && (cmd_i.kind == REQ_LOOKUP);
  assign wr_idx     = cmd_i.slot[IdxW-1:0];

  always_comb begin
    wr_entry.dest  = cmd_i.dest;
    wr_entry.mask  = cmd_i.mask;
    wr_entry.gw    = cmd_i.gw;
    wr_entry.iface = cmd_i.iface;
    wr_entry.len   = cmd_i.len;
  end

  // Strict compare while scanning upward keeps the lowest slot on a tie.
  assign hit    = rd_valid_q && (((addr_q ^ rd_q.dest) & rd_q.mask) == '0);
  assign better = chk_q && hit && (!found_q || (rd_q.len > len_q));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_scan) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          state_d = S_LAST;
        end
      end
      S_LAST: state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      addr_q <= cmd_i.dest;
    end
    if (better) begin
      gw_q    <= rd_q.gw;
      iface_q <= rd_q.iface;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      chk_q      <= 1'b0;
      rd_valid_q <= 1'b0;
      found_q    <= 1'b0;
      len_q      <= '0;
      for (int i = 0; i < EffDepth; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      chk_q      <= (state_q == S_SCAN);
      rd_valid_q <= valid_q[idx_q];
      if (wr_en) begin
        valid_q[wr_idx] <= cmd_i.valid;
      end
      if (start_scan) begin
        found_q <= 1'b0;
        len_q   <= '0;
      end else if (better) begin
        found_q <= 1'b1;
        len_q   <= rd_q.len;
      end
    end
  end

  assign done_o      = (state_q == S_OUT);
  assign found_o     = found_q;
  assign next_hop_o  = !found_q ? '0 : ((gw_q == '0) ? addr_q : gw_q);
  assign out_iface_o = found_q ? iface_q : '0;
  assign match_len_o = found_q ? len_q : '0;

endmodule

@@ hdl/route_longest_prefix_match.sv @@
// A lookup waits in the queue until the back end is idle; the back end then scans
// the first min(TABLE_DEPTH,32) slots and reports on done_o. A route write is
// applied when it leaves the queue. The scan reads one route slot per cycle from
// the table, and a new lookup starts only after the last one has reported.
// Reset clears all valid bits at once; no clearing pass. The receiver cannot stall:
// done_o is high for a single cycle, and the result ports hold until the next scan.
module route_longest_prefix_match #(
  parameter int TABLE_DEPTH = 32,
  parameter int IFACE_COUNT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [rlpm_pkg::SlotW-1:0]  slot_i,
  input  logic                        entry_valid_i,
  input  logic [rlpm_pkg::AddrW-1:0]  entry_dest_i,
  input  logic [rlpm_pkg::AddrW-1:0]  entry_mask_i,
  input  logic [rlpm_pkg::AddrW-1:0]  entry_gateway_i,
  input  logic [rlpm_pkg::IfaceW-1:0] entry_iface_i,
  input  logic [rlpm_pkg::AddrW-1:0]  lookup_addr_i,
  output logic                        done_o,
  output logic                        found_o,
  output logic [rlpm_pkg::AddrW-1:0]  next_hop_o,
  output logic [rlpm_pkg::IfaceW-1:0] out_iface_o,
  output logic [rlpm_pkg::LenW-1:0]   match_len_o
);
  import rlpm_pkg::*;

  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  cmd_t front_cmd;
  cmd_t back_cmd;

  // Hold off new requests only while the request queue is full.
  assign busy = q_full;

  // Front: classify each request, drop writes that would be ignored, and
  // precompute the prefix length of a written mask.
  rlpm_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IFACE_COUNT (IFACE_COUNT)
  ) u_front (
    .start           (start),
    .full_i          (q_full),
    .req_type_i      (req_type_i),
    .slot_i          (slot_i),
    .entry_valid_i   (entry_valid_i),
    .entry_dest_i    (entry_dest_i),
    .entry_mask_i    (entry_mask_i),
    .entry_gateway_i (entry_gateway_i),
    .entry_iface_i   (entry_iface_i),
    .lookup_addr_i   (lookup_addr_i),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  // Short queue so the front keeps taking requests while a scan runs.
  rlpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (back_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back: apply writes in order and scan the table for each lookup.
  rlpm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .done_o      (done_o),
    .found_o     (found_o),
    .next_hop_o  (next_hop_o),
    .out_iface_o (out_iface_o),
    .match_len_o (match_len_o)
  );

endmodule
